// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values, round functions and the record that
// passes from the input front end to the compression engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int QueueDepth = 4;
  localparam logic [7:0] PadByte = 8'h80;

  // One classified input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
  } sha_item_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// SHA-256 input front end
// Classifies input transfers and queues them for the engine; items with no
// byte and no end mark are dropped here.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_no_byte,
  input  logic               in_end,
  output logic               q_valid,
  input  logic               q_ready,
  output sha_pkg::sha_item_t q_item
);
  import sha_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  sha_item_t       fifo [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            push;
  logic            pop;

  assign in_ready = (count != (PtrW+1)'(QueueDepth));
  assign push     = in_valid && in_ready && (!in_no_byte || in_end);
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = fifo[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{data_byte: in_byte, has_byte: !in_no_byte, finish: in_end};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== rtl/sha_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Packs bytes into the block buffer, pads at the end of a message, runs one
// round per cycle and shows the digest words straight from the hash registers.
// ----------------------------------------------------------------------------
module sha_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  sha_pkg::sha_item_t q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_word,
  output logic [2:0]         out_index,
  output logic               out_last
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIN   = 6'b000010,
    S_ROUND = 6'b000100,
    S_ADD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] hash [8];
  logic [31:0] blk [16];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [63:0] msg_len;
  logic [5:0]  rnd;
  logic        fin_pend;   // message end seen, padding still to do
  logic        len_pend;   // second padding block still to compress
  logic        lenblk;     // running compression is the final one of a message
  logic [2:0]  out_cnt;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [4:0]  sh;
  logic [31:0] w_cur, w_new, t1, t2;

  assign pos  = msg_len[8:3];
  assign wsel = pos[5:2];
  assign sh   = {~pos[1:0], 3'b000};

  // Message schedule word for this round; first 16 come straight from the block
  always_comb begin
    w_new = small_s1(w[4'(rnd - 6'd2)]) + w[4'(rnd - 6'd7)]
          + small_s0(w[4'(rnd - 6'd15)]) + w[rnd[3:0]];
    w_cur = (rnd < 6'd16) ? blk[rnd[3:0]] : w_new;
    t1 = h + big_s1(e) + ((e & f) ^ (~e & g)) + RoundK[rnd] + w_cur;
    t2 = big_s0(a) + ((a & b) ^ (a & c) ^ (b & c));
  end

  assign q_ready   = (state == S_IDLE) && !fin_pend;
  assign out_valid = (state == S_OUT);
  assign out_word  = hash[out_cnt];
  assign out_index = out_cnt;
  assign out_last  = (out_cnt == 3'd7);

  // Block buffer, length and schedule
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_ready && q_item.has_byte) begin
      if (pos[1:0] == 2'd0) blk[wsel] <= 32'(q_item.data_byte) << sh;
      else blk[wsel] <= blk[wsel] | (32'(q_item.data_byte) << sh);
    end else if (state == S_FIN) begin
      for (int j = 0; j < 16; j++) begin
        if (4'(j) == wsel) begin
          if (pos[1:0] == 2'd0) blk[j] <= 32'(PadByte) << sh;
          else blk[j] <= blk[j] | (32'(PadByte) << sh);
        end else if (4'(j) > wsel) begin
          blk[j] <= '0;
        end
      end
      if (pos < 6'd56) begin
        blk[14] <= msg_len[63:32];
        blk[15] <= msg_len[31:0];
      end
    end else if (state == S_LEN) begin
      for (int j = 0; j < 14; j++) blk[j] <= '0;
      blk[14] <= msg_len[63:32];
      blk[15] <= msg_len[31:0];
    end
    if (state == S_ROUND) w[rnd[3:0]] <= w_cur;
  end

  // Control, working variables and hash words
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      msg_len  <= '0;
      rnd      <= '0;
      fin_pend <= 1'b0;
      len_pend <= 1'b0;
      out_cnt  <= '0;
      for (int j = 0; j < 8; j++) hash[j] <= InitH[j];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (fin_pend) begin
            state <= S_FIN;
          end else if (q_valid) begin
            if (q_item.has_byte) msg_len <= msg_len + 64'd8;
            fin_pend <= q_item.finish;
            if (q_item.has_byte && pos == 6'd63) begin
              state <= S_ROUND;
              {a, b, c, d, e, f, g, h} <= {hash[0], hash[1], hash[2], hash[3],
                                            hash[4], hash[5], hash[6], hash[7]};
              rnd <= '0;
            end
          end
        end
        S_FIN: begin
          fin_pend <= 1'b0;
          len_pend <= (pos >= 6'd56);
          state    <= S_ROUND;
          rnd      <= '0;
          {a, b, c, d, e, f, g, h} <= {hash[0], hash[1], hash[2], hash[3],
                                        hash[4], hash[5], hash[6], hash[7]};
        end
        S_LEN: begin
          len_pend <= 1'b0;
          state    <= S_ROUND;
          rnd      <= '0;
          {a, b, c, d, e, f, g, h} <= {hash[0], hash[1], hash[2], hash[3],
                                        hash[4], hash[5], hash[6], hash[7]};
        end
        S_ROUND: begin
          {b, c, d, f, g, h} <= {a, b, c, e, f, g};
          e   <= d + t1;
          a   <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          hash[0] <= hash[0] + a;
          hash[1] <= hash[1] + b;
          hash[2] <= hash[2] + c;
          hash[3] <= hash[3] + d;
          hash[4] <= hash[4] + e;
          hash[5] <= hash[5] + f;
          hash[6] <= hash[6] + g;
          hash[7] <= hash[7] + h;
          if (len_pend) state <= S_LEN;
          else if (fin_pend) state <= S_IDLE;
          else if (lenblk) state <= S_OUT;
          else state <= S_IDLE;
          out_cnt <= '0;
        end
        S_OUT: begin
          if (out_ready) begin
            out_cnt <= out_cnt + 3'd1;
            if (out_cnt == 3'd7) begin
              state   <= S_IDLE;
              msg_len <= '0;
              for (int j = 0; j < 8; j++) hash[j] <= InitH[j];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Marks that the running compression is the final one of a message
  always_ff @(posedge clk) begin
    if (rst) lenblk <= 1'b0;
    else if (state == S_FIN) lenblk <= (pos < 6'd56);
    else if (state == S_LEN) lenblk <= 1'b1;
    else if (state == S_ADD) lenblk <= 1'b0;
  end

endmodule

// ===== rtl/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: a byte, a no-byte flag and the
//   end-of-message mark in tlast. An item with no byte and no end mark is
//   dropped. After an end mark, m_axis gives eight transfers, digest word 0
//   (most significant) first, with tlast on word 7.
//   Bytes enter a four-entry queue, so input keeps flowing while the engine
//   compresses, until the queue fills. The engine takes in a byte whenever
//   it is idle; after each full 64-byte block it runs the 64 rounds at one
//   per cycle and then the final add (the round state loads in the cycle of
//   the last byte). At the end of a message it writes the padding and runs
//   one compression, plus a second one when the length needs its own block,
//   then gives the eight words. The single shared round unit sets the rate.
//   Reset returns the hash to the initial values and clears the length and
//   queue. When m_axis_tready is low the current word holds and the engine
//   waits; the queue then fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // no_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
  output logic        m_axis_tlast
);
  import sha_pkg::*;

  logic        q_valid;
  logic        q_ready;
  sha_item_t   q_item;
  logic [31:0] out_word;
  logic [2:0]  out_index;

  sha_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_no_byte(s_axis_tuser), .in_end(s_axis_tlast),
    .q_valid, .q_ready, .q_item
  );

  sha_engine u_engine (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_word, .out_index, .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_index, out_word};

  // Checks
  a_last_on_seven: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast not on word 7");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    else $error("digest words not consecutive");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams messages of random length and content into the hasher with random
// gaps and output stalls, predicts each digest with a local SHA-256 model
// and checks the eight digest transfers per message field by field.
// ----------------------------------------------------------------------------

// Digest predictor and store of expected digest words
class digest_scoreboard;
  logic [31:0] hash_state [8];
  logic [7:0]  msg_bytes [$];
  logic [63:0] bit_count;
  logic [35:0] pending_words [$];   // {last, index, word}
  int          error_count;

  function void restart();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::InitH[i];
    msg_bytes.delete();
    bit_count = '0;
  endfunction

  function void append_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  function logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function void compress(input logic [31:0] blk [16]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, e, a;
    for (int r = 0; r < 16; r++) w[r] = blk[r];
    for (int r = 16; r < 64; r++) begin
      w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10))
           + w[r-7] + w[r-16]
           + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3));
    end
    for (int j = 0; j < 8; j++) v[j] = hash_state[j];
    for (int r = 0; r < 64; r++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
         + ((e & v[5]) ^ (~e & v[6])) + sha_pkg::RoundK[r] + w[r];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
         + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] += v[j];
  endfunction

  // Block of 64 buffered bytes, big-endian words
  function void flush_block();
    logic [31:0] blk [16];
    for (int i = 0; i < 16; i++)
      blk[i] = {msg_bytes[4*i], msg_bytes[4*i+1], msg_bytes[4*i+2], msg_bytes[4*i+3]};
    repeat (64) void'(msg_bytes.pop_front());
    compress(blk);
  endfunction

  // Accepted input transfer
  function void note_input(input logic [7:0] data, input logic no_byte, input logic eom);
    logic [63:0] len;
    if (!no_byte) begin
      append_byte(data);
      bit_count += 64'd8;
      if (msg_bytes.size() == 64) flush_block();
    end
    if (!eom) return;
    len = bit_count;
    append_byte(8'h80);
    while (msg_bytes.size() % 64 != 56) append_byte(8'h00);
    for (int i = 7; i >= 0; i--) append_byte(len[8*i +: 8]);
    while (msg_bytes.size() > 0) flush_block();
    for (int j = 0; j < 8; j++)
      pending_words.insert(pending_words.size(), {(j == 7), 3'(j), hash_state[j]});
    restart();
  endfunction

  task report(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // Accepted output transfer
  task check_word(input logic [39:0] data, input logic last);
    logic [35:0] exp_word;
    if (pending_words.size() == 0) begin
      report($sformatf("unexpected digest word %h", data));
      return;
    end
    exp_word = pending_words.pop_front();
    if (data[31:0] !== exp_word[31:0])
      report($sformatf("word %0d: got %h want %h", exp_word[34:32], data[31:0], exp_word[31:0]));
    if (data[34:32] !== exp_word[34:32])
      report($sformatf("index: got %0d want %0d", data[34:32], exp_word[34:32]));
    if (data[39:35] !== 5'd0) report("nonzero upper tdata bits");
    if (last !== exp_word[35]) report($sformatf("tlast on word %0d wrong", exp_word[34:32]));
  endtask
endclass

module tb_top;
  import sha_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        feeding_done;

  digest_scoreboard sb;

  sha256_message_hasher DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  // One input transfer, with a random gap first
  task automatic send_item(input logic [7:0] data, input logic no_byte, input logic eom);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= no_byte;
    s_axis_tlast  <= eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(data, no_byte, eom);
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input logic eom_empty);
    for (int i = 0; i < len; i++) begin
      // occasional dropped item inside the message
      if ($urandom_range(0, 29) == 0) send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'($urandom), 1'b0, (i == len - 1) && !eom_empty);
    end
    if (eom_empty || len == 0) send_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_words.size() > 0) @(negedge clk);
  endtask

  // Output side: random stalls, sample at rising edge
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!feeding_done && $urandom_range(0, 60) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(20, 120)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0) || feeding_done;
      end
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
      @(negedge clk);
    end
  end

  initial begin
    int count;
    int len;
    int dir_lens [4];
    dir_lens = '{55, 56, 63, 64};
    sb = new();
    sb.restart();
    feeding_done  = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty message, "abc", byte extremes, pad boundaries
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'h63, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_drained();
    count = 8;
    // Lengths across the one/two final block boundary, and a full block
    foreach (dir_lens[i]) begin
      len = dir_lens[i];
      send_message(len, 1'($urandom_range(0, 1)));
      count += len;
    end
    wait_drained();

    // Random: mostly short messages, a few longer ones
    while (count < 380) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 3) == 0);
      count += len + 1;
      if ($urandom_range(0, 5) == 0) send_item(8'($urandom), 1'b1, 1'b0);
    end
    s_axis_tvalid <= 1'b0;
    feeding_done = 1'b1;
    while (sb.pending_words.size() > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.error_count == 0 && sb.pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_engine.sv
rtl/sha256_message_hasher.sv
test/tb_top.sv
